@@ design/ntc_pkg.sv @@
`default_nettype none
package ntc_pkg;

  localparam int unsigned RomSize = 206;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusFail  = 2'd1;
  localparam logic [1:0] StatusRange = 2'd2;

  localparam logic [1:0] RegVref   = 2'd0;
  localparam logic [1:0] RegRup    = 2'd1;
  localparam logic [1:0] RegGain   = 2'd2;
  localparam logic [1:0] RegOffset = 2'd3;

  localparam logic [23:0] MinDiffUv = 24'd10000;

  typedef logic [19:0] res_t;

  // resistance table, falling, one entry per degree
  function automatic res_t rom_value(input logic [7:0] idx);
    res_t r;
    r = '0;
    case (idx)
      8'd0: r = 20'd636177; 8'd1: r = 20'd594705; 8'd2: r = 20'd556217;
      8'd3: r = 20'd520480; 8'd4: r = 20'd487280; 8'd5: r = 20'd456420;
      8'd6: r = 20'd427721; 8'd7: r = 20'd401018; 8'd8: r = 20'd376161;
      8'd9: r = 20'd353009; 8'd10: r = 20'd331435; 8'd11: r = 20'd311323;
      8'd12: r = 20'd292563; 8'd13: r = 20'd275057; 8'd14: r = 20'd258714;
      8'd15: r = 20'd243448; 8'd16: r = 20'd229182; 8'd17: r = 20'd215846;
      8'd18: r = 20'd203371; 8'd19: r = 20'd191699; 8'd20: r = 20'd180771;
      8'd21: r = 20'd170537; 8'd22: r = 20'd160948; 8'd23: r = 20'd151960;
      8'd24: r = 20'd143530; 8'd25: r = 20'd135622; 8'd26: r = 20'd128200;
      8'd27: r = 20'd121231; 8'd28: r = 20'd114685; 8'd29: r = 20'd108534;
      8'd30: r = 20'd102751; 8'd31: r = 20'd97313; 8'd32: r = 20'd92196;
      8'd33: r = 20'd87380; 8'd34: r = 20'd82846; 8'd35: r = 20'd78575;
      8'd36: r = 20'd74551; 8'd37: r = 20'd70757; 8'd38: r = 20'd67180;
      8'd39: r = 20'd63806; 8'd40: r = 20'd60622; 8'd41: r = 20'd57616;
      8'd42: r = 20'd54778; 8'd43: r = 20'd52096; 8'd44: r = 20'd49563;
      8'd45: r = 20'd47167; 8'd46: r = 20'd44902; 8'd47: r = 20'd42759;
      8'd48: r = 20'd40732; 8'd49: r = 20'd38812; 8'd50: r = 20'd36995;
      8'd51: r = 20'd35273; 8'd52: r = 20'd33642; 8'd53: r = 20'd32096;
      8'd54: r = 20'd30630; 8'd55: r = 20'd29239; 8'd56: r = 20'd27920;
      8'd57: r = 20'd26668; 8'd58: r = 20'd25480; 8'd59: r = 20'd24351;
      8'd60: r = 20'd23279; 8'd61: r = 20'd22261; 8'd62: r = 20'd21293;
      8'd63: r = 20'd20372; 8'd64: r = 20'd19497; 8'd65: r = 20'd18664;
      8'd66: r = 20'd17872; 8'd67: r = 20'd17117; 8'd68: r = 20'd16399;
      8'd69: r = 20'd15715; 8'd70: r = 20'd15064; 8'd71: r = 20'd14443;
      8'd72: r = 20'd13851; 8'd73: r = 20'd13287; 8'd74: r = 20'd12749;
      8'd75: r = 20'd12236; 8'd76: r = 20'd11746; 8'd77: r = 20'd11279;
      8'd78: r = 20'd10833; 8'd79: r = 20'd10406; 8'd80: r = 20'd10000;
      8'd81: r = 20'd9611; 8'd82: r = 20'd9239; 8'd83: r = 20'd8884;
      8'd84: r = 20'd8544; 8'd85: r = 20'd8220; 8'd86: r = 20'd7909;
      8'd87: r = 20'd7612; 8'd88: r = 20'd7328; 8'd89: r = 20'd7055;
      8'd90: r = 20'd6795; 8'd91: r = 20'd6545; 8'd92: r = 20'd6306;
      8'd93: r = 20'd6077; 8'd94: r = 20'd5857; 8'd95: r = 20'd5647;
      8'd96: r = 20'd5445; 8'd97: r = 20'd5252; 8'd98: r = 20'd5066;
      8'd99: r = 20'd4888; 8'd100: r = 20'd4717; 8'd101: r = 20'd4553;
      8'd102: r = 20'd4396; 8'd103: r = 20'd4244; 8'd104: r = 20'd4099;
      8'd105: r = 20'd3960; 8'd106: r = 20'd3826; 8'd107: r = 20'd3697;
      8'd108: r = 20'd3573; 8'd109: r = 20'd3454; 8'd110: r = 20'd3340;
      8'd111: r = 20'd3230; 8'd112: r = 20'd3124; 8'd113: r = 20'd3022;
      8'd114: r = 20'd2924; 8'd115: r = 20'd2830; 8'd116: r = 20'd2739;
      8'd117: r = 20'd2652; 8'd118: r = 20'd2567; 8'd119: r = 20'd2486;
      8'd120: r = 20'd2408; 8'd121: r = 20'd2333; 8'd122: r = 20'd2260;
      8'd123: r = 20'd2190; 8'd124: r = 20'd2123; 8'd125: r = 20'd2058;
      8'd126: r = 20'd1995; 8'd127: r = 20'd1935; 8'd128: r = 20'd1876;
      8'd129: r = 20'd1820; 8'd130: r = 20'd1766; 8'd131: r = 20'd1713;
      8'd132: r = 20'd1663; 8'd133: r = 20'd1614; 8'd134: r = 20'd1567;
      8'd135: r = 20'd1521; 8'd136: r = 20'd1477; 8'd137: r = 20'd1434;
      8'd138: r = 20'd1393; 8'd139: r = 20'd1353; 8'd140: r = 20'd1315;
      8'd141: r = 20'd1278; 8'd142: r = 20'd1242; 8'd143: r = 20'd1207;
      8'd144: r = 20'd1173; 8'd145: r = 20'd1141; 8'd146: r = 20'd1109;
      8'd147: r = 20'd1079; 8'd148: r = 20'd1050; 8'd149: r = 20'd1021;
      8'd150: r = 20'd993; 8'd151: r = 20'd967; 8'd152: r = 20'd941;
      8'd153: r = 20'd916; 8'd154: r = 20'd891; 8'd155: r = 20'd868;
      8'd156: r = 20'd845; 8'd157: r = 20'd823; 8'd158: r = 20'd802;
      8'd159: r = 20'd781; 8'd160: r = 20'd761; 8'd161: r = 20'd741;
      8'd162: r = 20'd722; 8'd163: r = 20'd704; 8'd164: r = 20'd686;
      8'd165: r = 20'd669; 8'd166: r = 20'd652; 8'd167: r = 20'd636;
      8'd168: r = 20'd620; 8'd169: r = 20'd605; 8'd170: r = 20'd590;
      8'd171: r = 20'd575; 8'd172: r = 20'd561; 8'd173: r = 20'd548;
      8'd174: r = 20'd534; 8'd175: r = 20'd521; 8'd176: r = 20'd509;
      8'd177: r = 20'd497; 8'd178: r = 20'd485; 8'd179: r = 20'd474;
      8'd180: r = 20'd462; 8'd181: r = 20'd452; 8'd182: r = 20'd441;
      8'd183: r = 20'd431; 8'd184: r = 20'd421; 8'd185: r = 20'd411;
      8'd186: r = 20'd402; 8'd187: r = 20'd393; 8'd188: r = 20'd384;
      8'd189: r = 20'd375; 8'd190: r = 20'd367; 8'd191: r = 20'd358;
      8'd192: r = 20'd350; 8'd193: r = 20'd343; 8'd194: r = 20'd335;
      8'd195: r = 20'd328; 8'd196: r = 20'd320; 8'd197: r = 20'd313;
      8'd198: r = 20'd307; 8'd199: r = 20'd300; 8'd200: r = 20'd294;
      8'd201: r = 20'd287; 8'd202: r = 20'd281; 8'd203: r = 20'd275;
      8'd204: r = 20'd269; 8'd205: r = 20'd264;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/ntc_if.sv @@
`default_nettype none
interface ntc_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] voltage_uv;
  logic        measure_ok;
  modport source (output valid, voltage_uv, measure_ok, input ready);
  modport sink (input valid, voltage_uv, measure_ok, output ready);
endinterface

interface ntc_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] temperature_q8;
  logic [1:0]         status;
  modport source (output valid, temperature_q8, status, input ready);
  modport sink (input valid, temperature_q8, status, output ready);
endinterface

interface ntc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ design/ntc_table_interp_temperature_unit.sv @@
`default_nettype none
// NTC thermistor temperature unit. Each request carries a divider voltage in
// microvolts and a measurement-valid flag. The unit derives the thermistor
// resistance V*Rup/(Vref-V) with a bit-serial divider, checks it against
// both ends of the table, and brackets it by binary search over a
// synchronous ROM (a probe state and a compare state per step, up to 8
// probes). It then interpolates with a second bit-serial divider and applies
// calibration gain and offset with saturation. A resistance outside the
// table (above the first entry or below the last entry) skips the search
// and is reported as out of range. A failed measurement or a Vref-V under
// 10 mV gives its result in the cycle after acceptance. One request is in
// flight at a time. A new request is taken only while the unit is idle and
// the output register is empty or is being read in that same cycle.
module ntc_table_interp_temperature_unit #(
  parameter int TableEntries  = 206,
  parameter int TableBaseTemp = -55
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ntc_in_if.sink    in_i,
  ntc_out_if.source out_o,
  ntc_cfg_if.sink   cfg_i
);

  localparam int Used = (TableEntries < ntc_pkg::RomSize) ? TableEntries : ntc_pkg::RomSize;
  localparam logic [7:0] LastIdx = 8'(Used - 1);
  localparam logic [8:0] UsedN = 9'(Used);
  localparam logic signed [8:0] BaseT = 9'(TableBaseTemp);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SDiv   = 4'd1;
  localparam logic [3:0] SChk0  = 4'd2;
  localparam logic [3:0] SChk1  = 4'd3;
  localparam logic [3:0] SProbe = 4'd4;
  localparam logic [3:0] SCmp   = 4'd5;
  localparam logic [3:0] SRd    = 4'd6;
  localparam logic [3:0] SRdLo  = 4'd7;
  localparam logic [3:0] SRdHi  = 4'd8;
  localparam logic [3:0] SFrac  = 4'd9;
  localparam logic [3:0] SMul   = 4'd10;
  localparam logic [3:0] SCal   = 4'd11;
  localparam logic [3:0] SOut   = 4'd12;
  localparam logic [3:0] SChk2  = 4'd13;

  logic [3:0] st_q, st_d;

  // configuration registers
  logic [23:0] vref_q;
  logic [19:0] rup_q;
  logic signed [23:0] gain_q;
  logic signed [15:0] ofs_q;

  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vref_q <= 24'd3300000;
      rup_q  <= 20'd10000;
      gain_q <= 24'sd65536;
      ofs_q  <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        ntc_pkg::RegVref:   vref_q <= cfg_i.data;
        ntc_pkg::RegRup:    rup_q <= cfg_i.data[19:0];
        ntc_pkg::RegGain:   gain_q <= cfg_i.data;
        ntc_pkg::RegOffset: ofs_q <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  // table ROM with registered read
  logic [7:0]  rom_addr;
  logic [19:0] rom_q;
  always_ff @(posedge clk_i) begin
    rom_q <= ntc_pkg::rom_value(rom_addr);
  end

  // datapath registers
  logic [43:0] num_q;      // dividend shifting out
  logic [24:0] rem_q;      // partial remainder
  logic [23:0] den_q;
  logic [43:0] quo_q;
  logic [5:0]  cnt_q;
  logic [8:0]  lo_q, hi_q;
  logic [19:0] r1_q;
  logic signed [23:0] t_q;
  logic signed [47:0] prod_q;
  logic signed [23:0] res_q;
  logic [1:0]  stat_q;
  logic        out_v_q, out_v_d;

  wire accept_in = in_i.valid && in_i.ready;
  wire [24:0] diff = {1'b0, vref_q} - {1'b0, in_i.voltage_uv};
  wire [8:0]  mid = 9'((10'(lo_q) + 10'(hi_q)) >> 1);
  wire [24:0] trial = {rem_q[23:0], num_q[43]};
  wire        take = trial >= {1'b0, den_q};
  wire [19:0] rval = quo_q[19:0];
  // interpolation segment and rounded fraction dividend 512*(r1-R)+(r1-r2)
  wire [19:0] seg_d = den_q[19:0] - rom_q;
  wire [29:0] frac_num = {1'b0, num_q[19:0], 9'd0} + 30'(seg_d);

  assign in_i.ready = (st_q == SIdle) && !(out_v_q && !out_o.ready);
  assign out_o.valid = out_v_q;
  assign out_o.temperature_q8 = res_q;
  assign out_o.status = stat_q;

  always_comb begin
    rom_addr = 8'(mid);
    unique case (st_q)
      SChk0: rom_addr = 8'd0;
      SChk1: rom_addr = LastIdx;
      SRd:   rom_addr = 8'(lo_q);
      SRdLo: rom_addr = 8'(hi_q);
      default: rom_addr = 8'(mid);
    endcase
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      SIdle:  if (accept_in && in_i.measure_ok && !diff[24] && diff[23:0] >= ntc_pkg::MinDiffUv)
                st_d = SDiv;
      SDiv:   if (cnt_q == 6'd0) st_d = SChk0;
      SChk0:  st_d = SChk1;
      SChk1:  st_d = (quo_q[43:20] != '0 || rval > rom_q) ? SOut : SChk2;
      SChk2:  st_d = (r1_q < rom_q) ? SOut : SProbe;
      SProbe: st_d = (hi_q - lo_q > 9'd1) ? SCmp : SRd;
      SCmp:   st_d = SProbe;
      SRd:    st_d = SRdLo;
      SRdLo:  st_d = (hi_q >= UsedN) ? SMul : SRdHi;
      SRdHi:  st_d = (seg_d == '0) ? SMul : SFrac;
      SFrac:  if (cnt_q == 6'd0) st_d = SMul;
      SMul:   st_d = SCal;
      SCal:   st_d = SOut;
      SOut:   st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  // output valid: early errors finish right after acceptance
  always_comb begin
    out_v_d = out_v_q;
    if (out_o.ready) out_v_d = 1'b0;
    if (st_q == SOut) out_v_d = 1'b1;
    if (st_q == SIdle && accept_in)
      out_v_d = !in_i.measure_ok || diff[24] || (diff[23:0] < ntc_pkg::MinDiffUv);
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      out_v_q <= out_v_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      SIdle: begin
        num_q <= 44'(in_i.voltage_uv) * 44'(rup_q);
        den_q <= diff[23:0];
        rem_q <= '0;
        quo_q <= '0;
        cnt_q <= 6'd43;
        if (accept_in) begin
          res_q <= '0;
          if (!in_i.measure_ok) stat_q <= ntc_pkg::StatusFail;
          else stat_q <= ntc_pkg::StatusRange;
        end
      end
      SDiv, SFrac: begin
        rem_q <= take ? trial - {1'b0, den_q} : trial;
        quo_q <= {quo_q[42:0], take};
        num_q <= {num_q[42:0], 1'b0};
        cnt_q <= cnt_q - 6'd1;
      end
      SChk0: begin
        lo_q <= '0;
        hi_q <= UsedN;
      end
      SChk1: r1_q <= rval;
      SChk2: begin
        if (r1_q >= rom_q) stat_q <= ntc_pkg::StatusOk;
      end
      SCmp: begin
        if (r1_q < rom_q) lo_q <= mid; else hi_q <= mid;
      end
      SRdLo: begin
        num_q <= 44'(rom_q - r1_q);
        den_q <= 24'(rom_q);
        t_q <= 24'((10'(signed'(BaseT)) + 10'(signed'({1'b0, lo_q}))) * 256);
      end
      SRdHi: begin
        rem_q <= 25'(frac_num[29:9]);
        num_q <= {frac_num[8:0], 35'd0};
        den_q <= 24'({seg_d, 1'b0});
        quo_q <= '0;
        cnt_q <= 6'd8;
      end
      SMul: begin
        if (hi_q < UsedN && den_q != '0)
          t_q <= t_q + 24'(quo_q[9:0]);
      end
      SCal: prod_q <= 48'(t_q) * 48'(gain_q) + 48'sd32768;
      SOut: begin
        if (stat_q == ntc_pkg::StatusOk) begin
          if (50'(prod_q >>> 16) + 50'(ofs_q) > 50'sd8388607) res_q <= 24'sd8388607;
          else if (50'(prod_q >>> 16) + 50'(ofs_q) < -50'sd8388608) res_q <= -24'sd8388608;
          else res_q <= 24'(50'(prod_q >>> 16) + 50'(ofs_q));
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != SIdle) |-> !in_i.ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> out_o.valid) else $error("result dropped");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != ntc_pkg::StatusOk) |-> out_o.temperature_q8 == '0)
    else $error("nonzero temperature on error");
  a_search_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == SProbe) |-> lo_q < hi_q) else $error("search bracket broken");
`endif

endmodule
`default_nettype wire
